// ===== hdl/kpa_pkg.sv =====
`timescale 1ns / 1ps

package kpa_pkg;

    // default cluster count and the number of centroid registers
    localparam int NUM_CLUSTERS_DEF  = 6;
    localparam int NUM_CENTROID_REGS = 6;

    // field widths
    localparam int PIXEL_W     = 8;
    localparam int CENTROID_W  = 16;
    localparam int CLUSTER_W   = 3;
    localparam int SUM_W       = 28;
    localparam int COUNT_W     = 21;
    localparam int CFG_INDEX_W = 3;

    // saturation limits of the accumulators
    localparam logic [SUM_W-1:0]   SUM_MAX   = {SUM_W{1'b1}};
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // centroid of a cluster that has no register (255.0)
    localparam logic [CENTROID_W-1:0] CENTROID_FIXED = 16'hFF00;

    // queue between classifier and accumulator
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // result item kinds
    localparam logic KIND_LABEL   = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef struct packed {
        logic [PIXEL_W-1:0]   pixel;
        logic [CLUSTER_W-1:0] cluster;
        logic                 first_pixel;
        logic                 last_pixel;
    } queue_item_t;

    typedef enum logic {
        BACK_LABEL,
        BACK_SUMMARY
    } back_state_t;

    // power-up centroid values
    function automatic logic [CENTROID_W-1:0] centroid_reset_value(input int k);
        logic [CENTROID_W-1:0] value;
        case (k)
            0:       value = 16'd0;
            1:       value = 16'd16640;
            2:       value = 16'd25600;
            3:       value = 16'd32000;
            4:       value = 16'd48640;
            default: value = CENTROID_FIXED;
        endcase
        return value;
    endfunction

endpackage

// ===== hdl/kpa_if.sv =====
`timescale 1ns / 1ps

// pixel channel
interface kpa_pixel_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel;
    logic       first_pixel;
    logic       last_pixel;

    modport source (output valid, output pixel, output first_pixel, output last_pixel,
                    input ready);
    modport sink   (input valid, input pixel, input first_pixel, input last_pixel,
                    output ready);
endinterface

// result channel
interface kpa_result_if;
    logic        valid;
    logic        ready;
    logic        item_kind;
    logic [2:0]  cluster;
    logic [27:0] pixel_sum;
    logic [20:0] pixel_count;
    logic        end_of_run;

    modport source (output valid, output item_kind, output cluster, output pixel_sum,
                    output pixel_count, output end_of_run, input ready);
    modport sink   (input valid, input item_kind, input cluster, input pixel_sum,
                    input pixel_count, input end_of_run, output ready);
endinterface

// ===== hdl/kpa_classify.sv =====
`timescale 1ns / 1ps

module kpa_classify #(
    parameter int NUM_CLUSTERS = kpa_pkg::NUM_CLUSTERS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    kpa_pixel_if.sink                           pixels,
    input  logic                                cfg_write,
    input  logic [kpa_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [kpa_pkg::CENTROID_W-1:0]      cfg_data,
    output logic                                push_valid,
    output kpa_pkg::queue_item_t                push_item,
    input  logic                                push_ready
);
    import kpa_pkg::*;

    logic [CENTROID_W-1:0] centroid_reg [NUM_CENTROID_REGS];
    logic [CENTROID_W-1:0] centroid [NUM_CLUSTERS];
    logic [CENTROID_W-1:0] scaled;
    logic [CENTROID_W-1:0] dist_next [NUM_CLUSTERS];

    logic [CENTROID_W-1:0] dist_reg [NUM_CLUSTERS];
    logic [PIXEL_W-1:0]    pixel_reg;
    logic                  first_reg;
    logic                  last_reg;
    logic                  stage_valid_reg;

    logic [CENTROID_W-1:0] best_dist;
    logic [CLUSTER_W-1:0]  best_idx;
    logic                  stage_advance;

    // centroid registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_CENTROID_REGS; k++)
            begin
                centroid_reg[k] <= centroid_reset_value(k);
            end
        end
        else
        begin
            for (int k = 0; k < NUM_CENTROID_REGS; k++)
            begin
                if (cfg_write && cfg_index == CFG_INDEX_W'(k) && k < NUM_CLUSTERS)
                begin
                    centroid_reg[k] <= cfg_data;
                end
            end
        end
    end

    // clusters past the register file keep a fixed centroid
    always_comb
    begin
        for (int k = 0; k < NUM_CLUSTERS; k++)
        begin
            centroid[k] = (k < NUM_CENTROID_REGS) ? centroid_reg[k] : CENTROID_FIXED;
        end
    end

    // absolute distances in 8.8
    always_comb
    begin
        scaled = {pixels.pixel, 8'h00};
        for (int k = 0; k < NUM_CLUSTERS; k++)
        begin
            dist_next[k] = (scaled >= centroid[k]) ? (scaled - centroid[k])
                                                   : (centroid[k] - scaled);
        end
    end

    // distance stage, moves on when it is empty or the queue takes the previous item
    assign stage_advance = !stage_valid_reg || push_ready;
    assign pixels.ready  = stage_advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (stage_advance)
        begin
            stage_valid_reg <= pixels.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_advance && pixels.valid)
        begin
            dist_reg  <= dist_next;
            pixel_reg <= pixels.pixel;
            first_reg <= pixels.first_pixel;
            last_reg  <= pixels.last_pixel;
        end
    end

    // nearest centroid, ties to the lowest index
    always_comb
    begin
        best_dist = dist_reg[0];
        best_idx  = '0;
        for (int k = 1; k < NUM_CLUSTERS; k++)
        begin
            if (dist_reg[k] < best_dist)
            begin
                best_dist = dist_reg[k];
                best_idx  = CLUSTER_W'(k);
            end
        end
    end

    assign push_valid             = stage_valid_reg;
    assign push_item.pixel        = pixel_reg;
    assign push_item.cluster      = best_idx;
    assign push_item.first_pixel  = first_reg;
    assign push_item.last_pixel   = last_reg;

endmodule

// ===== hdl/kpa_fifo.sv =====
`timescale 1ns / 1ps

module kpa_fifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push_valid,
    input  kpa_pkg::queue_item_t push_item,
    output logic                 push_ready,
    output logic                 pop_valid,
    output kpa_pkg::queue_item_t pop_item,
    input  logic                 pop
);
    import kpa_pkg::*;

    queue_item_t       mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (count_reg != (QPTR_W+1)'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;
    assign pop_item   = mem[rd_ptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== hdl/kpa_accum.sv =====
`timescale 1ns / 1ps

module kpa_accum #(
    parameter int NUM_CLUSTERS = kpa_pkg::NUM_CLUSTERS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 pop_valid,
    input  kpa_pkg::queue_item_t pop_item,
    output logic                 pop,
    kpa_result_if.source         results
);
    import kpa_pkg::*;

    localparam int IDX_W = $clog2(NUM_CLUSTERS);

    back_state_t          state_reg;
    back_state_t          state_next;
    logic [IDX_W-1:0]     idx_reg;
    logic [IDX_W-1:0]     idx_next;
    logic                 idx_last;

    logic [SUM_W-1:0]     sums_reg [NUM_CLUSTERS];
    logic [SUM_W-1:0]     sums_next [NUM_CLUSTERS];
    logic [COUNT_W-1:0]   counts_reg [NUM_CLUSTERS];
    logic [COUNT_W-1:0]   counts_next [NUM_CLUSTERS];
    logic [SUM_W-1:0]     sum_base;
    logic [COUNT_W-1:0]   count_base;
    logic [SUM_W:0]       sum_wide;

    logic                 res_valid_reg;
    logic                 res_valid_next;
    logic                 res_kind_reg;
    logic                 res_kind_next;
    logic [CLUSTER_W-1:0] res_cluster_reg;
    logic [CLUSTER_W-1:0] res_cluster_next;
    logic [SUM_W-1:0]     res_sum_reg;
    logic [SUM_W-1:0]     res_sum_next;
    logic [COUNT_W-1:0]   res_count_reg;
    logic [COUNT_W-1:0]   res_count_next;
    logic                 res_end_reg;
    logic                 res_end_next;
    logic                 out_free;

    assign out_free = !res_valid_reg || results.ready;
    assign idx_last = (idx_reg == IDX_W'(NUM_CLUSTERS - 1));

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BACK_LABEL:
            begin
                if (pop_valid && out_free && pop_item.last_pixel)
                begin
                    state_next = BACK_SUMMARY;
                end
            end
            BACK_SUMMARY:
            begin
                if (out_free && idx_last)
                begin
                    state_next = BACK_LABEL;
                end
            end
            default:
            begin
                state_next = BACK_LABEL;
            end
        endcase
    end

    // queue pop and output register loads
    always_comb
    begin
        pop              = 1'b0;
        idx_next         = idx_reg;
        res_valid_next   = res_valid_reg && !results.ready;
        res_kind_next    = res_kind_reg;
        res_cluster_next = res_cluster_reg;
        res_sum_next     = res_sum_reg;
        res_count_next   = res_count_reg;
        res_end_next     = res_end_reg;
        unique case (state_reg)
            BACK_LABEL:
            begin
                if (pop_valid && out_free)
                begin
                    pop              = 1'b1;
                    idx_next         = '0;
                    res_valid_next   = 1'b1;
                    res_kind_next    = KIND_LABEL;
                    res_cluster_next = pop_item.cluster;
                    res_sum_next     = '0;
                    res_count_next   = '0;
                    res_end_next     = !pop_item.last_pixel;
                end
            end
            BACK_SUMMARY:
            begin
                if (out_free)
                begin
                    idx_next         = idx_last ? '0 : idx_reg + 1'b1;
                    res_valid_next   = 1'b1;
                    res_kind_next    = KIND_SUMMARY;
                    res_cluster_next = CLUSTER_W'(idx_reg);
                    res_sum_next     = sums_reg[idx_reg];
                    res_count_next   = counts_reg[idx_reg];
                    res_end_next     = idx_last;
                end
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    // accumulator update on each popped pixel, with clear and saturation
    always_comb
    begin
        sum_base   = '0;
        count_base = '0;
        sum_wide   = '0;
        for (int k = 0; k < NUM_CLUSTERS; k++)
        begin
            sums_next[k]   = sums_reg[k];
            counts_next[k] = counts_reg[k];
            if (pop)
            begin
                sum_base   = pop_item.first_pixel ? '0 : sums_reg[k];
                count_base = pop_item.first_pixel ? '0 : counts_reg[k];
                sums_next[k]   = sum_base;
                counts_next[k] = count_base;
                if (pop_item.cluster == CLUSTER_W'(k))
                begin
                    sum_wide = {1'b0, sum_base} + (SUM_W+1)'(pop_item.pixel);
                    sums_next[k] = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
                    counts_next[k] = (count_base == COUNT_MAX) ? COUNT_MAX
                                                               : count_base + 1'b1;
                end
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BACK_LABEL;
            idx_reg       <= '0;
            res_valid_reg <= 1'b0;
            for (int k = 0; k < NUM_CLUSTERS; k++)
            begin
                sums_reg[k]   <= '0;
                counts_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            res_valid_reg <= res_valid_next;
            sums_reg      <= sums_next;
            counts_reg    <= counts_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        res_kind_reg    <= res_kind_next;
        res_cluster_reg <= res_cluster_next;
        res_sum_reg     <= res_sum_next;
        res_count_reg   <= res_count_next;
        res_end_reg     <= res_end_next;
    end

    assign results.valid       = res_valid_reg;
    assign results.item_kind   = res_kind_reg;
    assign results.cluster     = res_cluster_reg;
    assign results.pixel_sum   = res_sum_reg;
    assign results.pixel_count = res_count_reg;
    assign results.end_of_run  = res_end_reg;

endmodule

// ===== hdl/kmeans_pixel_assign_accumulate.sv =====
// Path: a pixel's label is registered in the distance stage, the queue and the output
// register; summaries follow the last pixel's label back to back while results are taken.
// Throughput: one pixel per cycle while results are taken; a last pixel also brings
// NUM_CLUSTERS summary items, during which no pixel leaves the queue.
// Reset: centroids return to 0, 65, 100, 125, 190, 255 (8.8), sums and counts clear,
// queue and output register empty.
`timescale 1ns / 1ps

module kmeans_pixel_assign_accumulate #(
    parameter int NUM_CLUSTERS = kpa_pkg::NUM_CLUSTERS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    kpa_pixel_if.sink                       pixels,
    kpa_result_if.source                    results,
    input  logic                            cfg_write,
    input  logic [kpa_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [kpa_pkg::CENTROID_W-1:0]  cfg_data
);
    import kpa_pkg::*;

    logic        push_valid;
    logic        push_ready;
    queue_item_t push_item;
    logic        pop_valid;
    logic        pop;
    queue_item_t pop_item;

    // front: distances and nearest centroid
    kpa_classify #(
        .NUM_CLUSTERS (NUM_CLUSTERS)
    ) u_classify (
        .clk        (clk),
        .rst_n      (rst_n),
        .pixels     (pixels),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .push_valid (push_valid),
        .push_item  (push_item),
        .push_ready (push_ready)
    );

    // decoupling queue
    kpa_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_item  (push_item),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_item   (pop_item),
        .pop        (pop)
    );

    // back: accumulate and emit
    kpa_accum #(
        .NUM_CLUSTERS (NUM_CLUSTERS)
    ) u_accum (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_item  (pop_item),
        .pop       (pop),
        .results   (results)
    );

endmodule

// ===== sim/kmeans_pixel_assign_accumulate_tb.sv =====
`timescale 1ns / 1ps

module kmeans_pixel_assign_accumulate_tb;

    import kpa_pkg::*;

    localparam int CLUSTERS = NUM_CLUSTERS_DEF;

    // configuration register indexes, spare ones have no centroid behind them
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_CENTROID_0,
        REG_CENTROID_1,
        REG_CENTROID_2,
        REG_CENTROID_3,
        REG_CENTROID_4,
        REG_CENTROID_5,
        REG_SPARE_6,
        REG_SPARE_7
    } cfg_reg_t;

    typedef struct packed {
        logic [PIXEL_W-1:0] pixel;
        logic               first_pixel;
        logic               last_pixel;
    } pixel_item_t;

    typedef struct packed {
        logic                 item_kind;
        logic [CLUSTER_W-1:0] cluster;
        logic [SUM_W-1:0]     pixel_sum;
        logic [COUNT_W-1:0]   pixel_count;
        logic                 end_of_run;
    } result_item_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_write;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CENTROID_W-1:0]  cfg_data;

    kpa_pixel_if  pix_ch ();
    kpa_result_if res_ch ();

    // centroid copy and running accumulators of the predictor
    logic [CENTROID_W-1:0] centroid_val [CLUSTERS];
    logic [SUM_W-1:0]      sum_acc      [CLUSTERS];
    logic [COUNT_W-1:0]    count_acc    [CLUSTERS];

    pixel_item_t  pixel_backlog [$];
    result_item_t awaited       [$];
    int           pixels_queued;
    int           pixels_sent;
    int           mismatches;
    bit           steady;

    kmeans_pixel_assign_accumulate #(
        .NUM_CLUSTERS (CLUSTERS)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .pixels    (pix_ch),
        .results   (res_ch),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 50 MHz clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // nearest centroid, label, accumulate, and summaries on a last pixel
    function automatic void classify_pixel(pixel_item_t it);
        logic [16:0]  scaled;
        logic [16:0]  distance;
        logic [16:0]  best_dist;
        int           best;
        result_item_t res;
        if (it.first_pixel)
        begin
            for (int k = 0; k < CLUSTERS; k++)
            begin
                sum_acc[k]   = '0;
                count_acc[k] = '0;
            end
        end
        scaled    = {1'b0, it.pixel, 8'h00};
        best      = 0;
        best_dist = '1;
        for (int k = 0; k < CLUSTERS; k++)
        begin
            distance = (scaled >= {1'b0, centroid_val[k]})
                     ? scaled - {1'b0, centroid_val[k]}
                     : {1'b0, centroid_val[k]} - scaled;
            // strict compare keeps the lowest index on a tie
            if (k == 0 || distance < best_dist)
            begin
                best_dist = distance;
                best      = k;
            end
        end
        res.item_kind   = KIND_LABEL;
        res.cluster     = best[CLUSTER_W-1:0];
        res.pixel_sum   = '0;
        res.pixel_count = '0;
        res.end_of_run  = !it.last_pixel;
        awaited.push_back(res);
        // saturating accumulate
        if (sum_acc[best] > SUM_MAX - SUM_W'(it.pixel))
            sum_acc[best] = SUM_MAX;
        else
            sum_acc[best] = sum_acc[best] + SUM_W'(it.pixel);
        if (count_acc[best] < COUNT_MAX)
            count_acc[best] = count_acc[best] + 1'b1;
        if (it.last_pixel)
        begin
            for (int k = 0; k < CLUSTERS; k++)
            begin
                res.item_kind   = KIND_SUMMARY;
                res.cluster     = k[CLUSTER_W-1:0];
                res.pixel_sum   = sum_acc[k];
                res.pixel_count = count_acc[k];
                res.end_of_run  = (k == CLUSTERS - 1);
                awaited.push_back(res);
            end
        end
    endfunction

    function automatic bit sender_gap();
        return !steady && ($urandom_range(99) < 30);
    endfunction

    // pixel driver: predict on each transfer, then present the next pixel or a gap
    always @(posedge clk or negedge rst_n)
    begin : pixel_driver
        pixel_item_t nxt;
        if (!rst_n)
        begin
            pix_ch.valid       <= 1'b0;
            pix_ch.pixel       <= '0;
            pix_ch.first_pixel <= 1'b0;
            pix_ch.last_pixel  <= 1'b0;
        end
        else
        begin
            if (pix_ch.valid && pix_ch.ready)
            begin
                classify_pixel({pix_ch.pixel, pix_ch.first_pixel, pix_ch.last_pixel});
                pixels_sent++;
            end
            if (!pix_ch.valid || pix_ch.ready)
            begin
                if (pixel_backlog.size() != 0 && !sender_gap())
                begin
                    nxt = pixel_backlog.pop_front();
                    pix_ch.valid       <= 1'b1;
                    pix_ch.pixel       <= nxt.pixel;
                    pix_ch.first_pixel <= nxt.first_pixel;
                    pix_ch.last_pixel  <= nxt.last_pixel;
                end
                else
                begin
                    pix_ch.valid <= 1'b0;
                end
            end
        end
    end

    // result stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_ch.ready <= 1'b0;
        else
            res_ch.ready <= steady || ($urandom_range(99) >= 30);
    end

    function automatic void check_field(string name, longint want, longint got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // result monitor: each transfer against the oldest expectation
    always @(posedge clk)
    begin : result_monitor
        result_item_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (awaited.size() == 0)
            begin
                $display({"%0t: unexpected result, expected none, ",
                          "actual kind %0d cluster %0d sum %0d count %0d end %0d"},
                         $time, res_ch.item_kind, res_ch.cluster, res_ch.pixel_sum,
                         res_ch.pixel_count, res_ch.end_of_run);
                mismatches++;
            end
            else
            begin
                want = awaited.pop_front();
                check_field("item_kind", want.item_kind, res_ch.item_kind);
                check_field("cluster", want.cluster, res_ch.cluster);
                check_field("pixel_sum", want.pixel_sum, res_ch.pixel_sum);
                check_field("pixel_count", want.pixel_count, res_ch.pixel_count);
                check_field("end_of_run", want.end_of_run, res_ch.end_of_run);
            end
        end
    end

    task automatic add_pixel(logic [PIXEL_W-1:0] p, logic first, logic last);
        pixel_backlog.push_back({p, first, last});
        pixels_queued++;
    endtask

    // mostly well-formed runs with random content, some stray pixels
    task automatic add_runs(int n);
        int left;
        int len;
        left = n;
        while (left > 0)
        begin
            if ($urandom_range(9) == 0)
            begin
                add_pixel(PIXEL_W'($urandom_range(255)), 1'($urandom_range(1)),
                          1'($urandom_range(1)));
                left--;
            end
            else
            begin
                len = ($urandom_range(7) == 0) ? $urandom_range(40, 80)
                                               : $urandom_range(1, 12);
                if (len > left)
                    len = left;
                for (int i = 0; i < len; i++)
                    add_pixel(PIXEL_W'($urandom_range(255)), i == 0, i == len - 1);
                left -= len;
            end
        end
    endtask

    // wait until every pixel is sent and every result is back
    task automatic settle();
        while (pixels_sent != pixels_queued || awaited.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [CENTROID_W-1:0] value);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        if (idx < NUM_CENTROID_REGS && idx < CLUSTERS)
            centroid_val[idx] = value;
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic write_all(logic [CENTROID_W-1:0] value);
        for (int k = 0; k < NUM_CENTROID_REGS; k++)
            write_reg(cfg_reg_t'(k), value);
    endtask

    // stimulus
    initial
    begin
        rst_n              = 1'b0;
        cfg_write          = 1'b0;
        cfg_index          = '0;
        cfg_data           = '0;
        pixels_queued      = 0;
        pixels_sent        = 0;
        mismatches         = 0;
        steady             = 1'b0;
        for (int k = 0; k < CLUSTERS; k++)
        begin
            centroid_val[k] = (k < NUM_CENTROID_REGS) ? centroid_reset_value(k)
                                                      : CENTROID_FIXED;
            sum_acc[k]      = '0;
            count_acc[k]    = '0;
        end
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // power-up centroids: exact hits, points either side of most boundaries, extremes
        add_pixel(8'd0, 1'b1, 1'b0);
        add_pixel(8'd255, 1'b0, 1'b0);
        add_pixel(8'd65, 1'b0, 1'b0);
        add_pixel(8'd32, 1'b0, 1'b0);
        add_pixel(8'd33, 1'b0, 1'b0);
        add_pixel(8'd82, 1'b0, 1'b0);
        add_pixel(8'd83, 1'b0, 1'b0);
        add_pixel(8'd112, 1'b0, 1'b0);
        add_pixel(8'd113, 1'b0, 1'b0);
        add_pixel(8'd157, 1'b0, 1'b0);
        add_pixel(8'd158, 1'b0, 1'b0);
        add_pixel(8'd223, 1'b0, 1'b1);
        // both flags on one pixel
        add_pixel(8'd77, 1'b1, 1'b1);
        settle();

        // ties, duplicate centroids, and writes to spare indexes
        write_reg(REG_CENTROID_0, 16'h1000);
        write_reg(REG_CENTROID_1, 16'h3000);
        write_reg(REG_CENTROID_2, 16'h8000);
        write_reg(REG_CENTROID_3, 16'h8000);
        write_reg(REG_CENTROID_4, 16'hFFFF);
        write_reg(REG_CENTROID_5, 16'h0000);
        write_reg(REG_SPARE_6, 16'h1234);
        write_reg(REG_SPARE_7, 16'hFFFF);
        add_pixel(8'd32, 1'b1, 1'b0);
        add_pixel(8'd8, 1'b0, 1'b0);
        add_pixel(8'd0, 1'b0, 1'b0);
        add_pixel(8'd128, 1'b0, 1'b0);
        add_pixel(8'd160, 1'b0, 1'b0);
        add_pixel(8'd255, 1'b0, 1'b0);
        add_pixel(8'd200, 1'b0, 1'b1);
        settle();

        // every centroid at zero, then every centroid at the top
        write_all(16'h0000);
        add_runs(60);
        settle();
        write_all(16'hFFFF);
        add_runs(60);
        settle();

        // random centroids, spare indexes included
        repeat (4)
        begin
            for (int k = 0; k < 8; k++)
                write_reg(cfg_reg_t'(k), CENTROID_W'($urandom_range(65535)));
            add_runs(80);
            settle();
        end

        // power-up values again, no idling on either side
        for (int k = 0; k < NUM_CENTROID_REGS; k++)
            write_reg(cfg_reg_t'(k), centroid_reset_value(k));
        steady = 1'b1;
        add_runs(60);
        settle();
        steady = 1'b0;

        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // watchdog
    initial
    begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/kpa_pkg.sv
hdl/kpa_if.sv
hdl/kpa_classify.sv
hdl/kpa_fifo.sv
hdl/kpa_accum.sv
hdl/kmeans_pixel_assign_accumulate.sv
sim/kmeans_pixel_assign_accumulate_tb.sv
